[sv/gzmd_pkg.sv]
// Shared types, constants and functions of the gzip member deframer.
// Used by gzmd_front, gzmd_back and gzip_member_deframer_unit; depends on nothing.
package gzmd_pkg;

   // Header parser phases, one-hot.
   typedef enum logic [8:0] {
      PH_FIXED   = 9'b000000001,
      PH_XLEN0   = 9'b000000010,
      PH_XLEN1   = 9'b000000100,
      PH_EXTRA   = 9'b000001000,
      PH_NAME    = 9'b000010000,
      PH_COMMENT = 9'b000100000,
      PH_HCRC0   = 9'b001000000,
      PH_HCRC1   = 9'b010000000,
      PH_BODY    = 9'b100000000
   } phase_type;

   // Fixed header bytes and flag bits.
   localparam logic [7:0] MAGIC0        = 8'h1f;
   localparam logic [7:0] MAGIC1        = 8'h8b;
   localparam logic [7:0] METHOD_DEFL   = 8'h08;
   localparam logic [7:0] FLG_RESERVED  = 8'he0;
   localparam int         FLG_HCRC      = 1;
   localparam int         FLG_EXTRA     = 2;
   localparam int         FLG_NAME      = 3;
   localparam int         FLG_COMMENT   = 4;
   localparam logic [3:0] FIXED_LEN     = 4'd10;
   localparam logic [3:0] IDX_MAGIC0    = 4'd0;
   localparam logic [3:0] IDX_MAGIC1    = 4'd1;
   localparam logic [3:0] IDX_METHOD    = 4'd2;
   localparam logic [3:0] IDX_FLAGS     = 4'd3;
   localparam logic [4:0] MIN_MEMBER    = 5'd18;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hffffffff;
   localparam logic [31:0] MAX_SIZE_RST = 32'hffffffff;
   localparam int         TAIL_LEN      = 8;

   // Register offsets on the configuration port (index field of paddr).
   localparam logic REG_MAX_OUTPUT_SIZE = 1'b0;

   // Item handed from the header parser to the trailer stage.
   typedef struct packed {
      logic [7:0] data;
      logic       is_body;
      logic       last;
      logic       hdr_ok;
      logic       too_short;
   } mid_item_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        done_res;
      logic        invalid;
      logic [31:0] trailer_crc;
      logic [31:0] trailer_size;
   } rsp_item_type;

   // One byte step of the reflected CRC-32.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   // Next optional header section after a given phase, as the flags select.
   function automatic phase_type next_section(input phase_type from, input logic [7:0] flags);
      logic before_name;
      logic before_comment;
      logic before_hcrc;
      phase_type nxt;
      before_name    = (from == PH_FIXED) || (from == PH_XLEN1) || (from == PH_EXTRA);
      before_comment = before_name || (from == PH_NAME);
      before_hcrc    = before_comment || (from == PH_COMMENT);
      if ((from == PH_FIXED) && flags[FLG_EXTRA]) begin
         nxt = PH_XLEN0;
      end else if (before_name && flags[FLG_NAME]) begin
         nxt = PH_NAME;
      end else if (before_comment && flags[FLG_COMMENT]) begin
         nxt = PH_COMMENT;
      end else if (before_hcrc && flags[FLG_HCRC]) begin
         nxt = PH_HCRC0;
      end else begin
         nxt = PH_BODY;
      end
      return nxt;
   endfunction

endpackage

[sv/gzmd_queue.sv]
// Small first-in first-out queue with show-ahead read, used between stages.
// Depends on nothing.
module gzmd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[sv/gzmd_front.sv]
// Header parser: checks the gzip header, runs the header CRC and classifies each byte.
// Depends on gzmd_pkg.
module gzmd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_take,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  mid_push,
   output gzmd_pkg::mid_item_type mid_item
);
   gzmd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  fixed_count_ff, fixed_count_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] extra_rem_ff, extra_rem_in;
   logic [7:0]  hcrc_low_ff, hcrc_low_in;
   logic [31:0] crc_ff, crc_in;
   logic [4:0]  total_ff, total_in;
   logic        error_ff, error_in;
   logic [31:0] crc_next;
   logic [15:0] xlen;

   assign crc_next = gzmd_pkg::crc_byte(crc_ff, in_byte);
   assign xlen     = {in_byte, extra_rem_ff[7:0]};

   // Per-byte header step.
   always_comb begin
      phase_in       = phase_ff;
      fixed_count_in = fixed_count_ff;
      flags_in       = flags_ff;
      extra_rem_in   = extra_rem_ff;
      hcrc_low_in    = hcrc_low_ff;
      crc_in         = crc_ff;
      error_in       = error_ff;
      total_in       = (total_ff < gzmd_pkg::MIN_MEMBER) ? total_ff + 1'b1 : total_ff;
      if (!error_ff) begin
         case (phase_ff)
            gzmd_pkg::PH_FIXED: begin
               if (((fixed_count_ff == gzmd_pkg::IDX_MAGIC0) && (in_byte != gzmd_pkg::MAGIC0)) ||
                   ((fixed_count_ff == gzmd_pkg::IDX_MAGIC1) && (in_byte != gzmd_pkg::MAGIC1)) ||
                   ((fixed_count_ff == gzmd_pkg::IDX_METHOD) &&
                    (in_byte != gzmd_pkg::METHOD_DEFL)) ||
                   ((fixed_count_ff == gzmd_pkg::IDX_FLAGS) &&
                    ((in_byte & gzmd_pkg::FLG_RESERVED) != '0))) begin
                  error_in = 1'b1;
               end
               if (fixed_count_ff == gzmd_pkg::IDX_FLAGS) begin
                  flags_in = in_byte;
               end
               crc_in         = crc_next;
               fixed_count_in = fixed_count_ff + 1'b1;
               if (fixed_count_in >= gzmd_pkg::FIXED_LEN) begin
                  phase_in = gzmd_pkg::next_section(gzmd_pkg::PH_FIXED, flags_ff);
               end
            end
            gzmd_pkg::PH_XLEN0: begin
               crc_in       = crc_next;
               extra_rem_in = {8'd0, in_byte};
               phase_in     = gzmd_pkg::PH_XLEN1;
            end
            gzmd_pkg::PH_XLEN1: begin
               crc_in       = crc_next;
               extra_rem_in = xlen;
               phase_in     = (xlen != '0) ? gzmd_pkg::PH_EXTRA :
                              gzmd_pkg::next_section(gzmd_pkg::PH_XLEN1, flags_ff);
            end
            gzmd_pkg::PH_EXTRA: begin
               crc_in       = crc_next;
               extra_rem_in = extra_rem_ff - 1'b1;
               if (extra_rem_in == '0) begin
                  phase_in = gzmd_pkg::next_section(gzmd_pkg::PH_EXTRA, flags_ff);
               end
            end
            gzmd_pkg::PH_NAME, gzmd_pkg::PH_COMMENT: begin
               crc_in = crc_next;
               if (in_byte == '0) begin
                  phase_in = gzmd_pkg::next_section(phase_ff, flags_ff);
               end
            end
            gzmd_pkg::PH_HCRC0: begin
               hcrc_low_in = in_byte;
               phase_in    = gzmd_pkg::PH_HCRC1;
            end
            gzmd_pkg::PH_HCRC1: begin
               if ((~crc_ff[15:0]) != {in_byte, hcrc_low_ff}) begin
                  error_in = 1'b1;
               end
               phase_in = gzmd_pkg::PH_BODY;
            end
            gzmd_pkg::PH_BODY: begin
               phase_in = gzmd_pkg::PH_BODY;
            end
            default: begin
               error_in = 1'b1;
            end
         endcase
      end
   end

   // Classification handed to the trailer stage.
   always_comb begin
      mid_item.data      = in_byte;
      mid_item.is_body   = !error_ff && (phase_ff == gzmd_pkg::PH_BODY);
      mid_item.last      = in_last;
      mid_item.hdr_ok    = !error_in && (phase_in == gzmd_pkg::PH_BODY);
      mid_item.too_short = (total_in < gzmd_pkg::MIN_MEMBER);
   end

   assign mid_push = in_take && (mid_item.is_body || in_last);

   // Parser state; the final byte returns it to the start of a member.
   always_ff @(posedge clock) begin
      if (reset || (in_take && in_last)) begin
         phase_ff       <= gzmd_pkg::PH_FIXED;
         fixed_count_ff <= '0;
         flags_ff       <= '0;
         extra_rem_ff   <= '0;
         hcrc_low_ff    <= '0;
         crc_ff         <= gzmd_pkg::CRC_INIT;
         total_ff       <= '0;
         error_ff       <= 1'b0;
      end else if (in_take) begin
         phase_ff       <= phase_in;
         fixed_count_ff <= fixed_count_in;
         flags_ff       <= flags_in;
         extra_rem_ff   <= extra_rem_in;
         hcrc_low_ff    <= hcrc_low_in;
         crc_ff         <= crc_in;
         total_ff       <= total_in;
         error_ff       <= error_in;
      end
   end

endmodule

[sv/gzmd_back.sv]
// Trailer stage: eight-byte delay line that releases payload and captures the trailer.
// Depends on gzmd_pkg.
module gzmd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_take,
   input  gzmd_pkg::mid_item_type  item,
   input  logic [31:0]            max_output_size,
   output logic                   rsp_push,
   output gzmd_pkg::rsp_item_type  rsp_item
);
   localparam int TL = gzmd_pkg::TAIL_LEN;
   localparam int FW = $clog2(TL + 1);
   localparam int IW = $clog2(TL);

   logic [7:0]    tail_ff [TL];
   logic [7:0]    tail_in [TL];
   logic [FW-1:0] fill_ff, fill_in;
   logic          full_line;
   logic          have_tail;
   logic [31:0]   crc_word, size_word;

   assign full_line = (fill_ff == FW'(TL));

   // Delay line step for a body byte.
   always_comb begin
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (item.is_body) begin
         if (full_line) begin
            for (int i = 0; i < TL - 1; i++) begin
               tail_in[i] = tail_ff[i + 1];
            end
            tail_in[TL - 1] = item.data;
         end else begin
            tail_in[fill_ff[IW-1:0]] = item.data;
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Trailer words come from the line as it stands after this byte.
   assign crc_word  = {tail_in[3], tail_in[2], tail_in[1], tail_in[0]};
   assign size_word = {tail_in[7], tail_in[6], tail_in[5], tail_in[4]};
   assign have_tail = item.hdr_ok && (fill_in == FW'(TL));

   // Result formatting.
   always_comb begin
      rsp_item.payload_valid = item.is_body && full_line;
      rsp_item.payload_byte  = rsp_item.payload_valid ? tail_ff[0] : 8'd0;
      rsp_item.done_res      = item.last;
      rsp_item.invalid       = item.last &&
                               (!have_tail || item.too_short || (size_word > max_output_size));
      rsp_item.trailer_crc   = (item.last && have_tail) ? crc_word : 32'd0;
      rsp_item.trailer_size  = (item.last && have_tail) ? size_word : 32'd0;
   end

   assign rsp_push = item_take && (rsp_item.payload_valid || item.last);

   // Fill count; the final byte of a member empties the line.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (item_take) begin
         fill_ff <= item.last ? '0 : fill_in;
      end
   end

   // Line contents are read only once written, so they need no reset.
   always_ff @(posedge clock) begin
      if (item_take) begin
         tail_ff <= tail_in;
      end
   end

endmodule

[sv/gzip_member_deframer_unit.sv]
// Top level of the gzip member deframer: header parser, queue, trailer stage, result queue.
// Depends on gzmd_pkg, gzmd_queue, gzmd_front and gzmd_back.
//
//   Channel  Ports                                   Transaction when
//   input    push, full, req_in_byte, req_is_last    push && !full
//   result   pop, empty, rsp_* fields                pop && !empty
//   config   psel, penable, pwrite, paddr, pwdata    psel && penable && pwrite && pready
//
// One byte is accepted per cycle while full is low; the header CRC byte step sets the parser's cycle time.
// A result reaches the rsp_ ports only after its byte has been written into the parser-to-trailer queue
// and the result itself has been written into the result queue.
// Each side stalls on its own: full rises only when the parser-to-trailer queue is full,
// and the trailer stage waits while the result queue is full.
// Reset is synchronous; no clearing pass follows.
module gzip_member_deframer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_is_last,
   input  logic        pop,
   output logic        empty,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_done_res,
   output logic        rsp_invalid,
   output logic [31:0] rsp_trailer_crc,
   output logic [31:0] rsp_trailer_size,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int MIDW = $bits(gzmd_pkg::mid_item_type);
   localparam int RSPW = $bits(gzmd_pkg::rsp_item_type);

   logic                   in_take;
   logic                   mid_push, mid_full, mid_empty, mid_take;
   gzmd_pkg::mid_item_type  mid_wr, mid_rd;
   logic [MIDW-1:0]        mid_rd_bits;
   logic                   rsp_push, rsp_full;
   gzmd_pkg::rsp_item_type  rsp_wr, rsp_rd;
   logic [RSPW-1:0]        rsp_rd_bits;
   logic [31:0]            max_size_ff;
   logic                   reg_sel;

   // Configuration register.
   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == gzmd_pkg::REG_MAX_OUTPUT_SIZE);
   assign prdata  = reg_sel ? max_size_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= gzmd_pkg::MAX_SIZE_RST;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         max_size_ff <= pwdata;
      end
   end

   // Header parser.
   assign full    = mid_full;
   assign in_take = push && !mid_full;

   gzmd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (in_take),
      .in_byte  (req_in_byte),
      .in_last  (req_is_last),
      .mid_push (mid_push),
      .mid_item (mid_wr)
   );

   // Queue between parser and trailer stage.
   gzmd_queue #(.WIDTH(MIDW), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wr),
      .full  (mid_full),
      .pop   (mid_take),
      .rdata (mid_rd_bits),
      .empty (mid_empty)
   );

   assign mid_rd   = gzmd_pkg::mid_item_type'(mid_rd_bits);
   assign mid_take = !mid_empty && !rsp_full;

   // Trailer stage.
   gzmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_take       (mid_take),
      .item            (mid_rd),
      .max_output_size (max_size_ff),
      .rsp_push        (rsp_push),
      .rsp_item        (rsp_wr)
   );

   // Result queue.
   gzmd_queue #(.WIDTH(RSPW), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rd_bits),
      .empty (empty)
   );

   assign rsp_rd            = gzmd_pkg::rsp_item_type'(rsp_rd_bits);
   assign rsp_payload_byte  = rsp_rd.payload_byte;
   assign rsp_payload_valid = rsp_rd.payload_valid;
   assign rsp_done_res      = rsp_rd.done_res;
   assign rsp_invalid       = rsp_rd.invalid;
   assign rsp_trailer_crc   = rsp_rd.trailer_crc;
   assign rsp_trailer_size  = rsp_rd.trailer_size;

endmodule
